// ===== design/pce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_pkg
// Shared widths, action codes and controller/datapath handshake structs for
// the piecewise cubic evaluator.
// ----------------------------------------------------------------------------
package pce_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int FRAC_BITS    = 16;
    localparam int DATA_W       = 32;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = SEG_W + 1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_write;   // store the segment, set up a write result
        logic load_query;   // latch x, clear the segment count, restart the scan at breakpoint 1
        logic scan_step;    // one breakpoint read / compare
        logic fetch;        // read the chosen segment
        logic calc_t;       // t = x - start, seed accumulator
        logic mul;          // product = acc * t
        logic add;          // acc = round(product) + coefficient
        logic load_out;     // move result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic last_stage;
    } t_dp_sts;

endpackage

// ===== design/pce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_ctrl
// Sequencer: accepts a beat; for an evaluate beat steps the breakpoint scan and
// the three Horner stages; then hands the result to the output register.
// ----------------------------------------------------------------------------
module pce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_action,
    input  logic              i_out_ready,
    input  pce_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output pce_pkg::t_dp_cmd  o_cmd
);
    import pce_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_TDIFF = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_PUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.load_write = 1'b1;
                        n_state          = S_PUT;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_TDIFF;
            end
            S_TDIFF: begin
                o_cmd.calc_t = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_sts.last_stage ? S_PUT : S_MUL;
            end
            S_PUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/pce_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_datapath
// Segment table memory, breakpoint counter, Horner multiply/round/saturate
// and the output payload register.
// ----------------------------------------------------------------------------
module pce_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pce_pkg::t_dp_cmd                   i_cmd,
    output pce_pkg::t_dp_sts                   o_sts,
    input  logic                               i_cfg_we,
    input  logic [pce_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  logic [pce_pkg::SEG_W-1:0]          i_segment_number,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_start_point,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_cubic_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_square_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_linear_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_constant_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_query_x,
    output logic signed [pce_pkg::DATA_W-1:0]  o_spline_value,
    output logic [pce_pkg::SEG_W-1:0]          o_chosen_segment,
    output logic                               o_overflow
);
    import pce_pkg::*;

    localparam int WIDE_W  = 2 * DATA_W + 2;
    localparam int PROD_W  = 2 * DATA_W;

    localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [WIDE_W-1:0] DATA_MAX   = WIDE_W'((64'(1) << (DATA_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] DATA_MIN   = -DATA_MAX - WIDE_W'(1);
    localparam logic [CNT_W-1:0]         SEG_LIMIT  = CNT_W'(MAX_SEGMENTS);

    typedef struct packed {
        logic signed [DATA_W-1:0] start;
        logic signed [DATA_W-1:0] c3;
        logic signed [DATA_W-1:0] c2;
        logic signed [DATA_W-1:0] c1;
        logic signed [DATA_W-1:0] c0;
    } t_seg_entry;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > DATA_MAX) begin
            r = DATA_MAX[DATA_W-1:0];
        end else if (v < DATA_MIN) begin
            r = DATA_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    t_seg_entry                r_table [MAX_SEGMENTS];
    t_seg_entry                r_rd_entry;
    logic [CNT_W-1:0]          r_segs_in_use;
    logic [CNT_W-1:0]          w_n_eff;
    logic signed [DATA_W-1:0]  r_x;
    logic [CNT_W-1:0]          r_k;
    logic                      r_pend;
    logic [SEG_W-1:0]          r_count;
    logic                      r_ovf;
    logic signed [DATA_W-1:0]  r_t;
    logic signed [DATA_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic [1:0]                r_stage;
    logic                      w_issue;
    logic                      w_rd_en;
    logic [SEG_W-1:0]          w_rd_addr;
    logic signed [WIDE_W-1:0]  w_diff;
    logic signed [WIDE_W-1:0]  w_sum;
    logic signed [DATA_W-1:0]  w_coeff;
    logic signed [PROD_W-1:0]  w_prod;

    // zero segments acts as one, more than the table acts as the full table
    always_comb begin
        if (r_segs_in_use == '0) begin
            w_n_eff = CNT_W'(1);
        end else if (r_segs_in_use > SEG_LIMIT) begin
            w_n_eff = SEG_LIMIT;
        end else begin
            w_n_eff = r_segs_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segs_in_use <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_segs_in_use <= i_cfg_wdata;
        end
    end

    // table memory: one write port, one registered read port
    assign w_issue   = i_cmd.scan_step && (r_k < w_n_eff);
    assign w_rd_en   = w_issue || i_cmd.fetch;
    assign w_rd_addr = i_cmd.fetch ? r_count : r_k[SEG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            r_table[i_segment_number] <= '{start: i_start_point, c3: i_cubic_coeff,
                                           c2: i_square_coeff, c1: i_linear_coeff,
                                           c0: i_constant_coeff};
        end
        if (w_rd_en) begin
            r_rd_entry <= r_table[w_rd_addr];
        end
    end

    assign o_sts.scan_done  = (r_k >= w_n_eff) && !r_pend;
    assign o_sts.last_stage = (r_stage == 2'd2);

    assign w_diff = WIDE_W'(r_x) - WIDE_W'(r_rd_entry.start);
    assign w_prod = PROD_W'(r_acc) * PROD_W'(r_t);

    always_comb begin
        case (r_stage)
            2'd0:    w_coeff = r_rd_entry.c2;
            2'd1:    w_coeff = r_rd_entry.c1;
            default: w_coeff = r_rd_entry.c0;
        endcase
    end

    // round half up, floor shift, then add the next coefficient
    assign w_sum = ((WIDE_W'(r_prod) + ROUND_HALF) >>> FRAC_BITS) + WIDE_W'(w_coeff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.load_query) begin
                r_k    <= CNT_W'(1);
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_k <= r_k + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            r_count <= i_segment_number;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
        end
        if (i_cmd.load_query) begin
            r_x     <= i_query_x;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end
        if (i_cmd.scan_step && r_pend && (r_rd_entry.start <= r_x)) begin
            r_count <= r_count + SEG_W'(1);
        end
        if (i_cmd.calc_t) begin
            r_t     <= sat_data(w_diff);
            r_acc   <= r_rd_entry.c3;
            r_stage <= 2'd0;
            if ((w_diff > DATA_MAX) || (w_diff < DATA_MIN)) begin
                r_ovf <= 1'b1;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.add) begin
            r_acc   <= sat_data(w_sum);
            r_stage <= r_stage + 2'd1;
            if ((w_sum > DATA_MAX) || (w_sum < DATA_MIN)) begin
                r_ovf <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            o_spline_value   <= r_acc;
            o_chosen_segment <= r_count;
            o_overflow       <= r_ovf;
        end
    end

endmodule

// ===== design/piecewise_cubic_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_cubic_evaluator
// Table of cubic segments in signed Q16.16; write beats load a segment,
// evaluate beats count breakpoints at or below x and run Horner's rule.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_ready   action, segment, coeffs, x
//   output    out        o_out_valid / i_out_ready value, segment, overflow
//   config    in         i_cfg_we                  i_cfg_wdata (segments in use)
//
// a write beat goes straight to the output stage; an evaluate beat scans breakpoints
// 1 to n - 1, one per memory read, n the clamped segment count, then runs the Horner stages.
// reset (synchronous, active low) sets segments in use to 1; table is not cleared.
// a result held in the output register does not block the next input beat;
// a finished result waits in its last state until the output register frees.
// ----------------------------------------------------------------------------
module piecewise_cubic_evaluator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_action,
    input  logic [pce_pkg::SEG_W-1:0]          i_segment_number,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_start_point,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_cubic_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_square_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_linear_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_constant_coeff,
    input  logic signed [pce_pkg::DATA_W-1:0]  i_query_x,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pce_pkg::DATA_W-1:0]  o_spline_value,
    output logic [pce_pkg::SEG_W-1:0]          o_chosen_segment,
    output logic                               o_overflow,
    input  logic                               i_cfg_we,
    input  logic [pce_pkg::CNT_W-1:0]          i_cfg_wdata
);
    import pce_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    pce_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_segment_number (i_segment_number),
        .i_start_point    (i_start_point),
        .i_cubic_coeff    (i_cubic_coeff),
        .i_square_coeff   (i_square_coeff),
        .i_linear_coeff   (i_linear_coeff),
        .i_constant_coeff (i_constant_coeff),
        .i_query_x        (i_query_x),
        .o_spline_value   (o_spline_value),
        .o_chosen_segment (o_chosen_segment),
        .o_overflow       (o_overflow)
    );

endmodule

// ===== test/piecewise_cubic_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_cubic_evaluator_tb
// Loads spline segment tables through the input channel and queries them with
// directed and random points under random input gaps and output stalls. Every
// result is checked against an in-bench model of the breakpoint count and the
// saturating Horner evaluation.
// ----------------------------------------------------------------------------
module piecewise_cubic_evaluator_tb;

    import pce_pkg::*;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam logic signed [DATA_W-1:0] FULL_POS = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] FULL_NEG = 32'sh8000_0000;

    typedef struct {
        logic                      action;
        logic [SEG_W-1:0]          segment;
        logic signed [DATA_W-1:0]  start;
        logic signed [DATA_W-1:0]  c3;
        logic signed [DATA_W-1:0]  c2;
        logic signed [DATA_W-1:0]  c1;
        logic signed [DATA_W-1:0]  c0;
        logic signed [DATA_W-1:0]  x;
    } t_spline_beat;

    typedef struct {
        logic signed [DATA_W-1:0]  value;
        logic [SEG_W-1:0]          segment;
        logic                      overflow;
    } t_spline_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_action = 1'b0;
    logic [SEG_W-1:0]           i_segment_number = '0;
    logic signed [DATA_W-1:0]   i_start_point = '0;
    logic signed [DATA_W-1:0]   i_cubic_coeff = '0;
    logic signed [DATA_W-1:0]   i_square_coeff = '0;
    logic signed [DATA_W-1:0]   i_linear_coeff = '0;
    logic signed [DATA_W-1:0]   i_constant_coeff = '0;
    logic signed [DATA_W-1:0]   i_query_x = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [DATA_W-1:0]   o_spline_value;
    logic [SEG_W-1:0]           o_chosen_segment;
    logic                       o_overflow;
    logic                       i_cfg_we = 1'b0;
    logic [CNT_W-1:0]           i_cfg_wdata = '0;

    // model state
    logic signed [DATA_W-1:0]   bp_table [MAX_SEGMENTS];
    logic signed [DATA_W-1:0]   c3_table [MAX_SEGMENTS];
    logic signed [DATA_W-1:0]   c2_table [MAX_SEGMENTS];
    logic signed [DATA_W-1:0]   c1_table [MAX_SEGMENTS];
    logic signed [DATA_W-1:0]   c0_table [MAX_SEGMENTS];
    logic [CNT_W-1:0]           model_segment_count = CNT_W'(1);

    t_spline_result             pending_results [$];
    int                         error_count = 0;
    bit                         in_gaps_on = 1'b1;
    bit                         out_stalls_on = 1'b1;
    longint                     span_lo = 0;
    longint                     span_hi = 0;

    piecewise_cubic_evaluator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_segment_number (i_segment_number),
        .i_start_point    (i_start_point),
        .i_cubic_coeff    (i_cubic_coeff),
        .i_square_coeff   (i_square_coeff),
        .i_linear_coeff   (i_linear_coeff),
        .i_constant_coeff (i_constant_coeff),
        .i_query_x        (i_query_x),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_spline_value   (o_spline_value),
        .o_chosen_segment (o_chosen_segment),
        .o_overflow       (o_overflow),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #3_000_000;
        $display("piecewise_cubic_evaluator: mismatch");
        $finish;
    end

    function automatic longint clamp_q16(input longint v, inout bit ovf);
        if (v > Q_MAX) begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // exact product, round half up to the fraction width, add, saturate
    function automatic longint horner_step(input longint acc, input longint t,
                                           input longint coeff, inout bit ovf);
        longint prod;
        prod = acc * t + (longint'(1) <<< (FRAC_BITS - 1));
        return clamp_q16((prod >>> FRAC_BITS) + coeff, ovf);
    endfunction

    function automatic t_spline_result predict_spline(input t_spline_beat b);
        t_spline_result   r;
        int               n;
        logic [SEG_W-1:0] seg;
        longint           t;
        longint           acc;
        bit               ovf;
        r.value = '0;
        r.segment = b.segment;
        r.overflow = 1'b0;
        ovf = 1'b0;
        if (b.action == ACT_WRITE) begin
            bp_table[b.segment] = b.start;
            c3_table[b.segment] = b.c3;
            c2_table[b.segment] = b.c2;
            c1_table[b.segment] = b.c1;
            c0_table[b.segment] = b.c0;
            return r;
        end
        n = int'(model_segment_count);
        if (n < 1) n = 1;
        if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
        // plain count of interior breakpoints at or below x, sorted or not
        seg = '0;
        for (int k = 1; k < n; k++) begin
            if (bp_table[SEG_W'(k)] <= b.x) seg++;
        end
        t = clamp_q16(longint'(b.x) - longint'(bp_table[seg]), ovf);
        acc = longint'(c3_table[seg]);
        acc = horner_step(acc, t, longint'(c2_table[seg]), ovf);
        acc = horner_step(acc, t, longint'(c1_table[seg]), ovf);
        acc = horner_step(acc, t, longint'(c0_table[seg]), ovf);
        r.value = acc[DATA_W-1:0];
        r.segment = seg;
        r.overflow = ovf;
        return r;
    endfunction

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] small_word(input int span);
        longint v;
        v = longint'($urandom_range(0, 2 * span)) - span;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] any_word();
        logic signed [DATA_W-1:0] w;
        case ($urandom_range(0, 9))
            0: w = FULL_POS;
            1: w = FULL_NEG;
            2: w = '0;
            3, 4: w = small_word(1 << 20);
            default: w = $urandom();
        endcase
        return w;
    endfunction

    function automatic t_spline_beat write_beat(input int seg,
            input logic signed [DATA_W-1:0] start, c3, c2, c1, c0);
        t_spline_beat b;
        b.action = ACT_WRITE;
        b.segment = seg[SEG_W-1:0];
        b.start = start;
        b.c3 = c3;
        b.c2 = c2;
        b.c1 = c1;
        b.c0 = c0;
        b.x = $urandom();
        return b;
    endfunction

    function automatic t_spline_beat query_beat(input logic signed [DATA_W-1:0] x);
        t_spline_beat b;
        b.action = ACT_EVAL;
        b.segment = SEG_W'($urandom());
        b.start = $urandom();
        b.c3 = $urandom();
        b.c2 = $urandom();
        b.c1 = $urandom();
        b.c0 = $urandom();
        b.x = x;
        return b;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_beat(input t_spline_beat b);
        int gap;
        gap = pick_gap(in_gaps_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= b.action;
        i_segment_number <= b.segment;
        i_start_point    <= b.start;
        i_cubic_coeff    <= b.c3;
        i_square_coeff   <= b.c2;
        i_linear_coeff   <= b.c1;
        i_constant_coeff <= b.c0;
        i_query_x        <= b.x;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_spline(b));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_segment_count(input logic [CNT_W-1:0] count);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_segment_count = count;
    endtask

    // ascending breakpoints with random spacing, some repeated
    task automatic load_sorted_table(input int count);
        longint bp;
        int     span;
        bit     linear_fit;
        span = 1 << $urandom_range(12, 24);
        linear_fit = ($urandom_range(0, 3) == 0);
        bp = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        span_lo = bp;
        for (int s = 0; s < count; s++) begin
            send_beat(write_beat(s, bp[DATA_W-1:0],
                                 linear_fit ? '0 : small_word(span),
                                 linear_fit ? '0 : small_word(span),
                                 small_word(span), small_word(span)));
            span_hi = bp;
            bp += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 'h40000);
        end
    endtask

    task automatic check_result();
        t_spline_result e;
        if (pending_results.size() == 0) begin
            report_error($sformatf("result beat with nothing expected: value %0h segment %0d",
                                   o_spline_value, o_chosen_segment));
            return;
        end
        e = pending_results.pop_front();
        if (o_spline_value !== e.value)
            report_error($sformatf("spline_value %0h, expected %0h",
                                   o_spline_value, e.value));
        if (o_chosen_segment !== e.segment)
            report_error($sformatf("chosen_segment %0d, expected %0d",
                                   o_chosen_segment, e.segment));
        if (o_overflow !== e.overflow)
            report_error($sformatf("overflow %0b, expected %0b", o_overflow, e.overflow));
    endtask

    // output side: check accepted beats, stall ready at random
    initial begin : result_side
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result();
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                hold = pick_gap(out_stalls_on);
                i_out_ready <= (hold == 0);
                if (hold > 0) hold--;
            end
        end
    end

    task automatic test_table_fill();
        set_segment_count(CNT_W'(MAX_SEGMENTS));
        load_sorted_table(MAX_SEGMENTS);
    endtask

    task automatic test_field_extremes();
        set_segment_count(CNT_W'(1));
        // linear fit 2.0 * t + 1.0
        send_beat(write_beat(0, '0, '0, '0, 32'sh0002_0000, 32'sh0001_0000));
        send_beat(query_beat(32'sh0003_0000));
        send_beat(query_beat(FULL_NEG));
        // half an lsb on either sign of t
        send_beat(write_beat(0, '0, '0, '0, 32'sh0000_8000, '0));
        send_beat(query_beat(32'sh0000_0001));
        send_beat(query_beat(32'shFFFF_FFFF));
        // full-scale coefficients, t saturates high
        send_beat(write_beat(0, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG));
        send_beat(query_beat(FULL_POS));
        send_beat(query_beat(FULL_NEG));
        // t saturates low
        send_beat(write_beat(0, FULL_POS, '0, '0, '0, FULL_POS));
        send_beat(query_beat(FULL_NEG));
    endtask

    task automatic test_segment_count_limits();
        send_beat(write_beat(MAX_SEGMENTS - 1, FULL_POS, '0, '0, '0, 32'sh1234_5678));
        // counts above the table act as a full table, zero acts as one
        set_segment_count(CNT_W'(127));
        send_beat(query_beat(FULL_POS));
        send_beat(query_beat(FULL_NEG));
        set_segment_count(CNT_W'(MAX_SEGMENTS + 1));
        send_beat(query_beat(FULL_POS));
        set_segment_count(CNT_W'(MAX_SEGMENTS));
        send_beat(query_beat(FULL_POS));
        set_segment_count(CNT_W'(0));
        send_beat(query_beat(FULL_POS));
    endtask

    task automatic test_unsorted_breakpoints();
        set_segment_count(CNT_W'(4));
        send_beat(write_beat(0, '0, '0, '0, 32'sh0001_0000, '0));
        send_beat(write_beat(1, 32'sh0005_0000, '0, 32'sh0000_4000, '0, 32'sh0001_0000));
        send_beat(write_beat(2, 32'sh0001_0000, 32'sh0000_2000, '0, '0, 32'sh0002_0000));
        send_beat(write_beat(3, 32'sh0003_0000, '0, '0, 32'shFFFF_0000, 32'sh0003_0000));
        // queries on and between the breakpoints
        send_beat(query_beat(32'sh0001_0000));
        send_beat(query_beat(32'sh0002_0000));
        send_beat(query_beat(32'sh0003_0000));
        send_beat(query_beat(32'sh0005_0000));
    endtask

    task automatic test_random_tables();
        int               sent;
        int               phase;
        int               pick;
        int               n;
        logic [CNT_W-1:0] count;
        longint           x;
        sent = 0;
        phase = 0;
        while (sent < 860) begin
            case (phase % 6)
                0: count = CNT_W'(1);
                1: count = CNT_W'(MAX_SEGMENTS);
                2: count = CNT_W'($urandom_range(2, 16));
                3: count = CNT_W'($urandom_range(17, MAX_SEGMENTS - 1));
                4: count = CNT_W'($urandom_range(MAX_SEGMENTS + 1, 127));
                default: count = CNT_W'($urandom_range(0, 127));
            endcase
            set_segment_count(count);
            n = (count == 0) ? 1 : (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
            in_gaps_on = (phase % 4 != 3);
            out_stalls_on = (phase % 4 != 3);
            if ($urandom_range(0, 3) != 0) begin
                load_sorted_table(n);
                sent += n;
            end
            repeat (60) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // around the loaded span, a little past both ends
                    x = span_lo - 'h40000
                        + longint'($urandom_range(0, int'(span_hi - span_lo) + 'h80000));
                    send_beat(query_beat(x[DATA_W-1:0]));
                end else if (pick < 80) begin
                    send_beat(query_beat(bp_table[SEG_W'($urandom_range(0, n - 1))]));
                end else if (pick < 90) begin
                    send_beat(query_beat(any_word()));
                end else begin
                    send_beat(write_beat($urandom_range(0, MAX_SEGMENTS - 1), any_word(),
                                         any_word(), any_word(), any_word(), any_word()));
                end
                sent++;
            end
            phase++;
        end
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_table_fill();
        test_field_extremes();
        test_segment_count_limits();
        test_unsorted_breakpoints();
        test_random_tables();
        drain_results();
        repeat (80) @(posedge i_clk);
        if (error_count == 0) begin
            $display("piecewise_cubic_evaluator: match");
        end else begin
            $display("piecewise_cubic_evaluator: mismatch");
        end
        $finish;
    end

endmodule
